>>> hdl/poae_pkg.sv
package poae_pkg;

  // Geometry
  localparam int BLOCK_COUNT  = 64;
  localparam int LEVELS       = 7;
  localparam int BUCKET_SLOTS = 4;
  localparam int BLOCK_WORDS  = 4;
  localparam int STASH_DEPTH  = 32;
  localparam int WORD_W       = 32;

  localparam int IDX_W        = $clog2(BLOCK_COUNT);
  localparam int LEAF_W       = LEVELS - 1;
  localparam int BUCKET_COUNT = (1 << LEVELS) - 1;
  localparam int NUM_SLOTS    = BUCKET_COUNT * BUCKET_SLOTS;
  localparam int BKT_W        = $clog2(BUCKET_COUNT);
  localparam int PAY_AW       = $clog2(NUM_SLOTS);
  localparam int LVL_W        = $clog2(LEVELS);
  localparam int SLOT_W       = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int FILL_W       = $clog2(BUCKET_SLOTS + 1);
  localparam int CNT_W        = $clog2(STASH_DEPTH + 1);
  localparam int ST_AW        = $clog2(STASH_DEPTH);
  localparam int BLK_W        = BLOCK_WORDS * WORD_W;
  localparam int TAG_W        = IDX_W + 1;
  localparam int ROW_W        = BUCKET_SLOTS * TAG_W;
  localparam int ENT_W        = IDX_W + BLK_W;

  // One slot tag: valid flag over block index
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef tag_t [BUCKET_SLOTS-1:0] row_t;

  // One stash entry
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [BLK_W-1:0] data;
  } ent_t;

  function automatic logic [LEAF_W-1:0] bit_rev(input logic [LEAF_W-1:0] v);
    logic [LEAF_W-1:0] r;
    for (int i = 0; i < LEAF_W; i++) begin
      r[LEAF_W-1-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [BKT_W-1:0] bucket_of(input logic [LEAF_W-1:0] leaf,
                                                 input logic [LVL_W-1:0] lvl);
    logic [BKT_W-1:0]  base;
    logic [LEAF_W-1:0] off;
    base = BKT_W'((1 << lvl) - 1);
    off  = leaf >> (LEAF_W - int'(lvl));
    return base + BKT_W'(off);
  endfunction

  function automatic logic [PAY_AW-1:0] slot_addr(input logic [BKT_W-1:0] b,
                                                  input logic [FILL_W-1:0] s);
    return PAY_AW'(PAY_AW'(b) * PAY_AW'(BUCKET_SLOTS) + PAY_AW'(s));
  endfunction

endpackage

>>> hdl/poae_ram.sv
module poae_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Single write port, registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/path_oram_access_evict.sv
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    opcode, block index, random leaf, four words
// out_     output     out_valid / out_ready  found, four read words, stash overflow
//
// One item at a time. The run grows with the copies of the block found on the old path, the
// occupied slots on each eviction path and the stash fill at the search and at each bucket fill.
// Each step accesses the tag, payload, stash or position memory (one write port and one
// registered read port each), so the stash scans dominate.
// After reset the tag memory is cleared one bucket a cycle (in_ready low).
// A finished result waits in the output register; the next item is taken meanwhile.
module path_oram_access_evict
  import poae_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [0:0]         in_opcode,
  input  logic [5:0]         in_block_index,
  input  logic [5:0]         in_new_leaf_random,
  input  logic signed [31:0] in_write_word0,
  input  logic signed [31:0] in_write_word1,
  input  logic signed [31:0] in_write_word2,
  input  logic signed [31:0] in_write_word3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [0:0]         out_found,
  output logic signed [31:0] out_read_word0,
  output logic signed [31:0] out_read_word1,
  output logic signed [31:0] out_read_word2,
  output logic signed [31:0] out_read_word3,
  output logic [0:0]         out_stash_overflow
);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_POS     = 5'd2;
  localparam logic [4:0] S_POSW    = 5'd3;
  localparam logic [4:0] S_PR_TAG  = 5'd4;
  localparam logic [4:0] S_PR_ROW  = 5'd5;
  localparam logic [4:0] S_PR_S    = 5'd6;
  localparam logic [4:0] S_PR_P    = 5'd7;
  localparam logic [4:0] S_PR_WB   = 5'd8;
  localparam logic [4:0] S_SS_RD   = 5'd9;
  localparam logic [4:0] S_SS_CHK  = 5'd10;
  localparam logic [4:0] S_SH_RD   = 5'd11;
  localparam logic [4:0] S_SH_WR   = 5'd12;
  localparam logic [4:0] S_PUSH    = 5'd13;
  localparam logic [4:0] S_EV      = 5'd14;
  localparam logic [4:0] S_ER_TAG  = 5'd15;
  localparam logic [4:0] S_ER_ROW  = 5'd16;
  localparam logic [4:0] S_ER_S    = 5'd17;
  localparam logic [4:0] S_ER_P    = 5'd18;
  localparam logic [4:0] S_EF_INIT = 5'd19;
  localparam logic [4:0] S_EF_RD   = 5'd20;
  localparam logic [4:0] S_EF_POS  = 5'd21;
  localparam logic [4:0] S_EF_DEC  = 5'd22;
  localparam logic [4:0] S_EF_WB   = 5'd23;
  localparam logic [4:0] S_DONE    = 5'd24;

  logic [4:0]             state_r, state_nxt;
  logic [BKT_W-1:0]       clr_r, clr_nxt;
  logic                   op_r, op_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [LEAF_W-1:0]      nleaf_r, nleaf_nxt;
  logic [BLK_W-1:0]       wdat_r, wdat_nxt;
  logic [BLK_W-1:0]       blk_r, blk_nxt;
  logic                   found_r, found_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [LEAF_W-1:0]      leaf_r, leaf_nxt;
  logic [LVL_W-1:0]       l_r, l_nxt;
  logic [SLOT_W-1:0]      s_r, s_nxt;
  row_t                   row_r, row_nxt;
  logic [CNT_W-1:0]       i_r, i_nxt;
  logic [CNT_W-1:0]       k_r, k_nxt;
  logic [CNT_W-1:0]       keep_r, keep_nxt;
  logic [FILL_W-1:0]      filled_r, filled_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [LEAF_W-1:0]      ectr_r, ectr_nxt;
  logic                   ev_r, ev_nxt;
  ent_t                   ent_r, ent_nxt;
  logic [BLOCK_COUNT-1:0] pvld_r, pvld_nxt;
  logic                   oval_r, oval_nxt;
  logic                   ofound_r, ofound_nxt;
  logic                   oovf_r, oovf_nxt;
  logic [BLK_W-1:0]       odata_r, odata_nxt;

  // Memory ports
  logic                  tag_we;
  logic [BKT_W-1:0]      tag_waddr, tag_raddr;
  logic [ROW_W-1:0]      tag_wdata, tag_rdata;
  logic                  pay_we;
  logic [PAY_AW-1:0]     pay_waddr, pay_raddr;
  logic [BLK_W-1:0]      pay_wdata, pay_rdata;
  logic                  st_we;
  logic [ST_AW-1:0]      st_waddr, st_raddr;
  logic [ENT_W-1:0]      st_wdata, st_rdata;
  logic                  pos_we;
  logic [IDX_W-1:0]      pos_waddr, pos_raddr;
  logic [LEAF_W-1:0]     pos_wdata, pos_rdata;

  logic [BKT_W-1:0]      bkt;
  tag_t                  cur_tag;
  ent_t                  st_ent;
  logic [LEAF_W-1:0]     ent_leaf;
  logic [LEAF_W-1:0]     leaf_diff;
  logic                  on_path;
  logic                  last_slot;
  logic [CNT_W-1:0]      km1;

  poae_ram #(.W(ROW_W), .D(BUCKET_COUNT)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  poae_ram #(.W(BLK_W), .D(NUM_SLOTS)) u_pay_ram (
    .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
    .raddr(pay_raddr), .rdata(pay_rdata)
  );

  poae_ram #(.W(ENT_W), .D(STASH_DEPTH)) u_stash_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  poae_ram #(.W(LEAF_W), .D(BLOCK_COUNT)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  // Shared path and slot helpers
  assign bkt       = bucket_of(leaf_r, l_r);
  assign cur_tag   = row_r[s_r];
  assign st_ent    = ent_t'(st_rdata);
  assign ent_leaf  = pvld_r[ent_r.idx] ? pos_rdata : '0;
  assign leaf_diff = (ent_leaf ^ leaf_r) >> (LVL_W'(LEAF_W) - l_r);
  assign on_path   = (filled_r < FILL_W'(BUCKET_SLOTS)) && (leaf_diff == '0);
  assign last_slot = (s_r == SLOT_W'(BUCKET_SLOTS - 1));
  assign km1       = k_r - CNT_W'(1);

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = oval_r;
  assign out_found          = ofound_r;
  assign out_stash_overflow = oovf_r;
  assign out_read_word0     = $signed(odata_r[0*WORD_W +: WORD_W]);
  assign out_read_word1     = $signed(odata_r[1*WORD_W +: WORD_W]);
  assign out_read_word2     = $signed(odata_r[2*WORD_W +: WORD_W]);
  assign out_read_word3     = $signed(odata_r[3*WORD_W +: WORD_W]);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    nleaf_nxt  = nleaf_r;
    wdat_nxt   = wdat_r;
    blk_nxt    = blk_r;
    found_nxt  = found_r;
    ovf_nxt    = ovf_r;
    leaf_nxt   = leaf_r;
    l_nxt      = l_r;
    s_nxt      = s_r;
    row_nxt    = row_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    keep_nxt   = keep_r;
    filled_nxt = filled_r;
    cnt_nxt    = cnt_r;
    ectr_nxt   = ectr_r;
    ev_nxt     = ev_r;
    ent_nxt    = ent_r;
    pvld_nxt   = pvld_r;
    oval_nxt   = oval_r & ~out_ready;
    ofound_nxt = ofound_r;
    oovf_nxt   = oovf_r;
    odata_nxt  = odata_r;

    tag_we    = 1'b0;
    tag_waddr = bkt;
    tag_wdata = row_r;
    tag_raddr = bkt;
    pay_we    = 1'b0;
    pay_waddr = slot_addr(bkt, filled_r);
    pay_wdata = ent_r.data;
    pay_raddr = slot_addr(bkt, FILL_W'(s_r));
    st_we     = 1'b0;
    st_waddr  = keep_r[ST_AW-1:0];
    st_wdata  = ent_r;
    st_raddr  = i_r[ST_AW-1:0];
    pos_we    = 1'b0;
    pos_waddr = idx_r;
    pos_wdata = nleaf_r;
    pos_raddr = idx_r;

    case (state_r)
      // Tag memory clearing pass
      S_CLR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_r;
        tag_wdata = '0;
        clr_nxt   = clr_r + BKT_W'(1);
        if (clr_r == BKT_W'(BUCKET_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode[0];
          idx_nxt   = in_block_index;
          nleaf_nxt = bit_rev(in_new_leaf_random[LEAF_W-1:0]);
          wdat_nxt  = {in_write_word3, in_write_word2, in_write_word1, in_write_word0};
          blk_nxt   = '0;
          found_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = S_POS;
        end
      end
      // Position lookup and remap
      S_POS: begin
        state_nxt = S_POSW;
      end
      S_POSW: begin
        leaf_nxt        = pvld_r[idx_r] ? pos_rdata : '0;
        pos_we          = 1'b1;
        pvld_nxt[idx_r] = 1'b1;
        l_nxt           = '0;
        state_nxt       = S_PR_TAG;
      end
      // Old path: pull out every copy of the block
      S_PR_TAG: begin
        state_nxt = S_PR_ROW;
      end
      S_PR_ROW: begin
        row_nxt   = row_t'(tag_rdata);
        s_nxt     = '0;
        state_nxt = S_PR_S;
      end
      S_PR_S: begin
        if (cur_tag.vld && cur_tag.idx == idx_r) begin
          state_nxt = S_PR_P;
        end else if (last_slot) begin
          state_nxt = S_PR_WB;
        end else begin
          s_nxt = s_r + SLOT_W'(1);
        end
      end
      S_PR_P: begin
        blk_nxt      = pay_rdata;
        found_nxt    = 1'b1;
        row_nxt[s_r] = '0;
        if (last_slot) begin
          state_nxt = S_PR_WB;
        end else begin
          s_nxt     = s_r + SLOT_W'(1);
          state_nxt = S_PR_S;
        end
      end
      S_PR_WB: begin
        tag_we = 1'b1;
        if (l_r == LVL_W'(LEVELS - 1)) begin
          i_nxt     = '0;
          state_nxt = S_SS_RD;
        end else begin
          l_nxt     = l_r + LVL_W'(1);
          state_nxt = S_PR_TAG;
        end
      end
      // Stash search, first match only
      S_SS_RD: begin
        if (i_r == cnt_r) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_SS_CHK;
        end
      end
      S_SS_CHK: begin
        if (st_ent.idx == idx_r) begin
          blk_nxt   = st_ent.data;
          found_nxt = 1'b1;
          k_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SH_RD;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SS_RD;
        end
      end
      // Close the gap left by the match
      S_SH_RD: begin
        st_raddr = k_r[ST_AW-1:0];
        if (k_r == cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        st_we     = 1'b1;
        st_waddr  = km1[ST_AW-1:0];
        st_wdata  = st_rdata;
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_SH_RD;
      end
      // Put the accessed block back into the stash if it was written or found
      S_PUSH: begin
        st_waddr = cnt_r[ST_AW-1:0];
        st_wdata = {idx_r, op_r ? wdat_r : blk_r};
        if (op_r || found_r) begin
          if (cnt_r == CNT_W'(STASH_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            st_we   = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        blk_nxt   = (!op_r && found_r) ? blk_r : '0;
        ev_nxt    = 1'b0;
        state_nxt = S_EV;
      end
      // Eviction: read the path into the stash
      S_EV: begin
        leaf_nxt  = bit_rev(ectr_r);
        ectr_nxt  = ectr_r + LEAF_W'(1);
        l_nxt     = '0;
        state_nxt = S_ER_TAG;
      end
      S_ER_TAG: begin
        state_nxt = S_ER_ROW;
      end
      S_ER_ROW: begin
        row_nxt   = row_t'(tag_rdata);
        s_nxt     = '0;
        state_nxt = S_ER_S;
      end
      S_ER_S, S_ER_P: begin
        if (state_r == S_ER_S && cur_tag.vld) begin
          state_nxt = S_ER_P;
        end else begin
          if (state_r == S_ER_P) begin
            st_waddr = cnt_r[ST_AW-1:0];
            st_wdata = {cur_tag.idx, pay_rdata};
            if (cnt_r == CNT_W'(STASH_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              st_we   = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          if (!last_slot) begin
            s_nxt     = s_r + SLOT_W'(1);
            state_nxt = S_ER_S;
          end else if (l_r == LVL_W'(LEVELS - 1)) begin
            state_nxt = S_EF_INIT;
          end else begin
            l_nxt     = l_r + LVL_W'(1);
            state_nxt = S_ER_TAG;
          end
        end
      end
      // Eviction: fill buckets leaf to root, oldest entries first
      S_EF_INIT: begin
        row_nxt    = '0;
        filled_nxt = '0;
        keep_nxt   = '0;
        i_nxt      = '0;
        state_nxt  = S_EF_RD;
      end
      S_EF_RD: begin
        if (i_r == cnt_r) begin
          state_nxt = S_EF_WB;
        end else begin
          state_nxt = S_EF_POS;
        end
      end
      S_EF_POS: begin
        ent_nxt   = st_ent;
        pos_raddr = st_ent.idx;
        state_nxt = S_EF_DEC;
      end
      S_EF_DEC: begin
        if (on_path) begin
          pay_we            = 1'b1;
          row_nxt[filled_r[SLOT_W-1:0]] = '{vld: 1'b1, idx: ent_r.idx};
          filled_nxt        = filled_r + FILL_W'(1);
        end else begin
          st_we    = 1'b1;
          keep_nxt = keep_r + CNT_W'(1);
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_EF_RD;
      end
      S_EF_WB: begin
        tag_we  = 1'b1;
        cnt_nxt = keep_r;
        if (l_r != '0) begin
          l_nxt     = l_r - LVL_W'(1);
          state_nxt = S_EF_INIT;
        end else if (!ev_r) begin
          ev_nxt    = 1'b1;
          state_nxt = S_EV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // Hand the result to the output register
      S_DONE: begin
        if (!oval_r || out_ready) begin
          oval_nxt   = 1'b1;
          ofound_nxt = found_r;
          oovf_nxt   = ovf_r;
          odata_nxt  = blk_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      cnt_r   <= '0;
      ectr_r  <= '0;
      pvld_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      ectr_r  <= ectr_nxt;
      pvld_r  <= pvld_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    nleaf_r  <= nleaf_nxt;
    wdat_r   <= wdat_nxt;
    blk_r    <= blk_nxt;
    found_r  <= found_nxt;
    ovf_r    <= ovf_nxt;
    leaf_r   <= leaf_nxt;
    l_r      <= l_nxt;
    s_r      <= s_nxt;
    row_r    <= row_nxt;
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    keep_r   <= keep_nxt;
    filled_r <= filled_nxt;
    ev_r     <= ev_nxt;
    ent_r    <= ent_nxt;
    ofound_r <= ofound_nxt;
    oovf_r   <= oovf_nxt;
    odata_r  <= odata_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STASH_DEPTH))
    else $error("stash count beyond depth");

  a_keep_le_i: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EF_RD) |-> (keep_r <= i_r))
    else $error("compaction write ahead of read");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EF_DEC) |-> (filled_r <= FILL_W'(BUCKET_SLOTS)))
    else $error("bucket overfilled");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(oval_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion");
`endif

endmodule
